// ----- hw/rtl/amf0vs_pkg.sv -----
// ----------------------------------------------------------------------------
// amf0vs_pkg
// Shared constants, codes and the token record for the AMF0 value parser.
// ----------------------------------------------------------------------------
`default_nettype none

package amf0vs_pkg;

  // Deepest object nesting accepted before a depth-overflow error.
  localparam int MAX_DEPTH = 15;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

  // Marker byte plus payload bytes of the fixed-size and header items.
  localparam int NUMBER_ITEM = 9;
  localparam int DATE_ITEM   = 11;
  localparam int LONG_HDR    = 5;
  localparam int SHORT_HDR   = 3;

  // Parse phases
  localparam logic [2:0] PH_TYPE       = 3'd0;
  localparam logic [2:0] PH_NAME_HI    = 3'd1;
  localparam logic [2:0] PH_NAME_LO    = 3'd2;
  localparam logic [2:0] PH_NAME_BYTES = 3'd3;
  localparam logic [2:0] PH_FIXED      = 3'd4;
  localparam logic [2:0] PH_LEN        = 3'd5;
  localparam logic [2:0] PH_STR        = 3'd6;

  // Type markers
  localparam logic [7:0] M_NUMBER  = 8'd0;
  localparam logic [7:0] M_BOOL    = 8'd1;
  localparam logic [7:0] M_STRING  = 8'd2;
  localparam logic [7:0] M_OBJECT  = 8'd3;
  localparam logic [7:0] M_NULL    = 8'd5;
  localparam logic [7:0] M_UNDEF   = 8'd6;
  localparam logic [7:0] M_REF     = 8'd7;
  localparam logic [7:0] M_OBJ_END = 8'd9;
  localparam logic [7:0] M_DATE    = 8'd11;
  localparam logic [7:0] M_LONG    = 8'd12;
  localparam logic [7:0] M_XML     = 8'd15;

  // Token kinds
  localparam logic [3:0] TK_NUMBER    = 4'd0;
  localparam logic [3:0] TK_BOOL      = 4'd1;
  localparam logic [3:0] TK_STR_HDR   = 4'd2;
  localparam logic [3:0] TK_STR_BYTE  = 4'd3;
  localparam logic [3:0] TK_OBJ_START = 4'd4;
  localparam logic [3:0] TK_OBJ_END   = 4'd5;
  localparam logic [3:0] TK_NULL      = 4'd6;
  localparam logic [3:0] TK_UNDEF     = 4'd7;
  localparam logic [3:0] TK_REF       = 4'd8;
  localparam logic [3:0] TK_DATE      = 4'd9;
  localparam logic [3:0] TK_NAME_LEN  = 4'd10;
  localparam logic [3:0] TK_NAME_BYTE = 4'd11;
  localparam logic [3:0] TK_ERROR     = 4'd12;

  // String kinds
  localparam logic [1:0] SK_SHORT = 2'd0;
  localparam logic [1:0] SK_LONG  = 2'd1;
  localparam logic [1:0] SK_XML   = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_UNSUPPORTED = 3'd1;
  localparam logic [2:0] ERR_INCOMPLETE  = 3'd2;
  localparam logic [2:0] ERR_DEPTH       = 3'd3;
  localparam logic [2:0] ERR_UNBALANCED  = 3'd4;

  typedef logic [DEPTH_W-1:0] depth_t;

  typedef struct packed {
    logic [3:0]         token_kind;
    logic [63:0]        token_value;
    logic signed [15:0] time_zone;
    logic [1:0]         string_kind;
    logic [3:0]         nest_depth;
    logic [2:0]         error_code;
  } token_t;

endpackage

`default_nettype wire

// ----- hw/rtl/amf0vs_msg_if.sv -----
// ----------------------------------------------------------------------------
// amf0vs_msg_if
// Byte channel into the parser: one message byte and its end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface amf0vs_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source(output valid, data_byte, end_of_message, input ready);
  modport sink(input valid, data_byte, end_of_message, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/amf0vs_token_if.sv -----
// ----------------------------------------------------------------------------
// amf0vs_token_if
// Token channel out of the parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface amf0vs_token_if;
  logic               valid;
  logic               ready;
  logic [3:0]         token_kind;
  logic [63:0]        token_value;
  logic signed [15:0] time_zone;
  logic [1:0]         string_kind;
  logic [3:0]         nest_depth;
  logic [2:0]         error_code;

  modport source(output valid, token_kind, token_value, time_zone, string_kind,
                 nest_depth, error_code, input ready);
  modport sink(input valid, token_kind, token_value, time_zone, string_kind,
               nest_depth, error_code, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/amf0vs_core.sv -----
// ----------------------------------------------------------------------------
// amf0vs_core
// Parse state and the one-byte step: next state and the token it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module amf0vs_core (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  step,
  input  wire  [7:0]           data_byte,
  input  wire                  end_of_message,
  output amf0vs_pkg::token_t   tok,
  output logic                 tok_valid
);

  logic [2:0]          phase, phase_next;
  logic [4:0]          ctype, ctype_next;
  logic [31:0]         rem, rem_next;
  logic [63:0]         shift_reg, shift_reg_next;
  logic [15:0]         zone, zone_next;
  amf0vs_pkg::depth_t  depth, depth_next;
  logic                halted, halted_next;

  logic [31:0]         rem_dec;
  logic [15:0]         name_len;
  logic [1:0]          skind;
  logic [2:0]          bnd;
  logic                emit;
  amf0vs_pkg::token_t  t;

  assign rem_dec  = (rem != '0) ? rem - 32'd1 : '0;
  assign name_len = {shift_reg[7:0], data_byte};
  assign bnd      = (depth != '0) ? amf0vs_pkg::PH_NAME_HI : amf0vs_pkg::PH_TYPE;

  always_comb begin
    if (ctype == 5'(amf0vs_pkg::M_LONG)) begin
      skind = amf0vs_pkg::SK_LONG;
    end else if (ctype == 5'(amf0vs_pkg::M_XML)) begin
      skind = amf0vs_pkg::SK_XML;
    end else begin
      skind = amf0vs_pkg::SK_SHORT;
    end
  end

  always_comb begin
    phase_next     = phase;
    ctype_next     = ctype;
    rem_next       = rem;
    shift_reg_next = shift_reg;
    zone_next      = zone;
    depth_next     = depth;
    halted_next    = halted;
    emit           = 1'b0;
    t              = '0;

    if (!halted) begin
      unique case (phase)
        amf0vs_pkg::PH_NAME_HI: begin
          shift_reg_next = 64'(data_byte);
          phase_next     = amf0vs_pkg::PH_NAME_LO;
        end
        amf0vs_pkg::PH_NAME_LO: begin
          emit          = 1'b1;
          t.token_kind  = amf0vs_pkg::TK_NAME_LEN;
          t.token_value = 64'(name_len);
          rem_next      = 32'(name_len);
          phase_next    = (name_len != '0) ? amf0vs_pkg::PH_NAME_BYTES
                                           : amf0vs_pkg::PH_TYPE;
        end
        amf0vs_pkg::PH_NAME_BYTES: begin
          emit          = 1'b1;
          t.token_kind  = amf0vs_pkg::TK_NAME_BYTE;
          t.token_value = 64'(data_byte);
          rem_next      = rem_dec;
          if (rem_dec == '0) begin
            phase_next = amf0vs_pkg::PH_TYPE;
          end
        end
        amf0vs_pkg::PH_TYPE: begin
          ctype_next     = data_byte[4:0];
          shift_reg_next = '0;
          zone_next      = '0;
          unique case (data_byte) inside
            amf0vs_pkg::M_NUMBER: begin
              rem_next   = 32'(amf0vs_pkg::NUMBER_ITEM - 1);
              phase_next = amf0vs_pkg::PH_FIXED;
            end
            amf0vs_pkg::M_BOOL: begin
              rem_next   = 32'd1;
              phase_next = amf0vs_pkg::PH_FIXED;
            end
            amf0vs_pkg::M_REF: begin
              rem_next   = 32'd2;
              phase_next = amf0vs_pkg::PH_FIXED;
            end
            amf0vs_pkg::M_DATE: begin
              rem_next   = 32'(amf0vs_pkg::DATE_ITEM - 1);
              phase_next = amf0vs_pkg::PH_FIXED;
            end
            amf0vs_pkg::M_STRING: begin
              rem_next   = 32'(amf0vs_pkg::SHORT_HDR - 1);
              phase_next = amf0vs_pkg::PH_LEN;
            end
            amf0vs_pkg::M_LONG, amf0vs_pkg::M_XML: begin
              rem_next   = 32'(amf0vs_pkg::LONG_HDR - 1);
              phase_next = amf0vs_pkg::PH_LEN;
            end
            amf0vs_pkg::M_NULL: begin
              emit         = 1'b1;
              t.token_kind = amf0vs_pkg::TK_NULL;
              phase_next   = bnd;
            end
            amf0vs_pkg::M_UNDEF: begin
              emit         = 1'b1;
              t.token_kind = amf0vs_pkg::TK_UNDEF;
              phase_next   = bnd;
            end
            amf0vs_pkg::M_OBJECT: begin
              emit = 1'b1;
              if (depth >= amf0vs_pkg::DEPTH_W'(amf0vs_pkg::MAX_DEPTH)) begin
                halted_next  = 1'b1;
                t.token_kind = amf0vs_pkg::TK_ERROR;
                t.error_code = amf0vs_pkg::ERR_DEPTH;
              end else begin
                depth_next   = depth + amf0vs_pkg::DEPTH_W'(1);
                phase_next   = amf0vs_pkg::PH_NAME_HI;
                t.token_kind = amf0vs_pkg::TK_OBJ_START;
              end
            end
            amf0vs_pkg::M_OBJ_END: begin
              emit = 1'b1;
              if (depth == '0) begin
                halted_next  = 1'b1;
                t.token_kind = amf0vs_pkg::TK_ERROR;
                t.error_code = amf0vs_pkg::ERR_UNBALANCED;
              end else begin
                depth_next   = depth - amf0vs_pkg::DEPTH_W'(1);
                phase_next   = (depth_next != '0) ? amf0vs_pkg::PH_NAME_HI
                                                  : amf0vs_pkg::PH_TYPE;
                t.token_kind = amf0vs_pkg::TK_OBJ_END;
              end
            end
            default: begin
              emit         = 1'b1;
              halted_next  = 1'b1;
              t.token_kind = amf0vs_pkg::TK_ERROR;
              t.error_code = amf0vs_pkg::ERR_UNSUPPORTED;
            end
          endcase
        end
        amf0vs_pkg::PH_FIXED: begin
          // date: first two payload bytes are the timezone
          if (ctype == 5'(amf0vs_pkg::M_DATE) && rem > 32'd8) begin
            zone_next = {zone[7:0], data_byte};
          end else begin
            shift_reg_next = {shift_reg[55:0], data_byte};
          end
          rem_next = rem_dec;
          if (rem_dec == '0) begin
            emit       = 1'b1;
            phase_next = bnd;
            if (ctype == 5'(amf0vs_pkg::M_NUMBER)) begin
              t.token_kind  = amf0vs_pkg::TK_NUMBER;
              t.token_value = shift_reg_next;
            end else if (ctype == 5'(amf0vs_pkg::M_BOOL)) begin
              t.token_kind  = amf0vs_pkg::TK_BOOL;
              t.token_value = 64'(shift_reg_next[7:0]);
            end else if (ctype == 5'(amf0vs_pkg::M_REF)) begin
              t.token_kind  = amf0vs_pkg::TK_REF;
              t.token_value = 64'(shift_reg_next[15:0]);
            end else begin
              t.token_kind  = amf0vs_pkg::TK_DATE;
              t.token_value = shift_reg_next;
              t.time_zone   = zone_next;
            end
          end
        end
        amf0vs_pkg::PH_LEN: begin
          shift_reg_next = {shift_reg[55:0], data_byte};
          rem_next       = rem_dec;
          if (rem_dec == '0) begin
            emit          = 1'b1;
            t.token_kind  = amf0vs_pkg::TK_STR_HDR;
            t.token_value = 64'(shift_reg_next[31:0]);
            t.string_kind = skind;
            rem_next      = shift_reg_next[31:0];
            phase_next    = (shift_reg_next[31:0] != '0) ? amf0vs_pkg::PH_STR : bnd;
          end
        end
        amf0vs_pkg::PH_STR: begin
          emit          = 1'b1;
          t.token_kind  = amf0vs_pkg::TK_STR_BYTE;
          t.token_value = 64'(data_byte);
          t.string_kind = skind;
          rem_next      = rem_dec;
          if (rem_dec == '0) begin
            phase_next = bnd;
          end
        end
        default: begin
          phase_next = bnd;
        end
      endcase
    end

    // last byte: flag an unfinished item, then back to reset values
    if (end_of_message) begin
      if (!halted_next && phase_next != amf0vs_pkg::PH_TYPE &&
          phase_next != amf0vs_pkg::PH_NAME_HI) begin
        emit         = 1'b1;
        t            = '0;
        t.token_kind = amf0vs_pkg::TK_ERROR;
        t.error_code = amf0vs_pkg::ERR_INCOMPLETE;
      end
    end

    t.nest_depth = 4'(depth_next);

    if (end_of_message) begin
      phase_next     = amf0vs_pkg::PH_TYPE;
      ctype_next     = '0;
      rem_next       = '0;
      shift_reg_next = '0;
      zone_next      = '0;
      depth_next     = '0;
      halted_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= amf0vs_pkg::PH_TYPE;
      ctype     <= '0;
      rem       <= '0;
      shift_reg <= '0;
      zone      <= '0;
      depth     <= '0;
      halted    <= 1'b0;
    end else if (step) begin
      phase     <= phase_next;
      ctype     <= ctype_next;
      rem       <= rem_next;
      shift_reg <= shift_reg_next;
      zone      <= zone_next;
      depth     <= depth_next;
      halted    <= halted_next;
    end
  end

  assign tok       = t;
  assign tok_valid = emit;

endmodule

`default_nettype wire

// ----- hw/rtl/amf0_value_stream_parser.sv -----
// ----------------------------------------------------------------------------
// amf0_value_stream_parser
// A token is registered: its byte passes through the byte register and the parse
// step before it lands in the token register. One byte per cycle is taken while
// the token output is not stalled; a byte may cause no token.
// Reset (rst, synchronous): empties both registers and returns the parser to
// awaiting a type marker at depth zero.
// ----------------------------------------------------------------------------
`default_nettype none

module amf0_value_stream_parser (
  input  wire             clk,
  input  wire             rst,
  amf0vs_msg_if.sink      msg,
  amf0vs_token_if.source  token
);

  // Byte register: holds one accepted request until the parse step takes it.
  logic       byte_valid;
  logic [7:0] byte_data;
  logic       byte_eom;

  // Token register: holds one result until the sink takes it.
  logic               tok_reg_valid;
  amf0vs_pkg::token_t tok_reg;

  // Step output
  amf0vs_pkg::token_t step_tok;
  logic               step_tok_valid;

  // The byte in the register is parsed when the token register is free or
  // being emptied this cycle. Parse state only moves on a step.
  logic advance;
  assign advance = byte_valid && (!tok_reg_valid || token.ready);

  // Take a new byte whenever the byte register empties this cycle.
  assign msg.ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (msg.ready) begin
      byte_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      byte_data <= msg.data_byte;
      byte_eom  <= msg.end_of_message;
    end
  end

  amf0vs_core u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .data_byte      (byte_data),
    .end_of_message (byte_eom),
    .tok            (step_tok),
    .tok_valid      (step_tok_valid)
  );

  // Token register: a step that gives no token leaves it empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_reg_valid <= 1'b0;
    end else if (advance) begin
      tok_reg_valid <= step_tok_valid;
    end else if (token.ready) begin
      tok_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_tok_valid) begin
      tok_reg <= step_tok;
    end
  end

  assign token.valid       = tok_reg_valid;
  assign token.token_kind  = tok_reg.token_kind;
  assign token.token_value = tok_reg.token_value;
  assign token.time_zone   = tok_reg.time_zone;
  assign token.string_kind = tok_reg.string_kind;
  assign token.nest_depth  = tok_reg.nest_depth;
  assign token.error_code  = tok_reg.error_code;

  // Input is held back only by a full token register that is stalled.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !msg.ready |-> (byte_valid && tok_reg_valid && !token.ready))
    else $error("byte channel stalled without an output stall");

  // A step that makes a token always lands it in the token register.
  a_step_fills_out: assert property (@(posedge clk) disable iff (rst)
    (advance && step_tok_valid) |=> tok_reg_valid)
    else $error("parsed token lost");

  // Error code is set exactly on error tokens.
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    step_tok_valid |-> ((step_tok.token_kind == amf0vs_pkg::TK_ERROR) ==
                        (step_tok.error_code != amf0vs_pkg::ERR_NONE)))
    else $error("error code and token kind disagree");

  // String kind is only nonzero on string tokens.
  a_skind: assert property (@(posedge clk) disable iff (rst)
    (step_tok_valid && step_tok.string_kind != amf0vs_pkg::SK_SHORT) |->
      (step_tok.token_kind == amf0vs_pkg::TK_STR_HDR ||
       step_tok.token_kind == amf0vs_pkg::TK_STR_BYTE))
    else $error("string kind on a non-string token");

endmodule

`default_nettype wire
